/* hdl/swmv_pkg.sv */
// Package for the sliding-window majority vote block: sizes, widths and the
// control bundle shared between the top level and its vote-count cells.
// No dependencies.
package swmv_pkg;

   localparam int WINDOW      = 8;
   localparam int MAX_CLASSES = 16;

   // widths fixed by the channel fields and the register
   localparam int CLASS_W = 4;
   localparam int NCLS_W  = 5;

   // class indices are 4 bits wide, so no more than 16 classes can ever vote
   localparam int CLASS_SPAN = 1 << CLASS_W;
   localparam int TALLY_N    = (MAX_CLASSES < CLASS_SPAN) ? MAX_CLASSES : CLASS_SPAN;

   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int ROT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int IDX_W  = $clog2(TALLY_N);

   localparam logic [NCLS_W-1:0] NCLS_RESET = NCLS_W'(2);

   typedef logic [CLASS_W-1:0] class_type;
   typedef logic [CNT_W-1:0]   count_type;

   // control for one vote-count cell
   typedef struct packed {
      logic clear;
      logic shift;
      logic inc;
   } tally_ctl_type;

endpackage

/* hdl/swmv_req_if.sv */
// Input channel of the majority vote block: valid/ready plus the class index.
// Depends on swmv_pkg.
interface swmv_req_if;
   import swmv_pkg::*;

   logic      valid;
   logic      ready;
   class_type class_in;

   modport source (output valid, output class_in, input ready);
   modport sink   (input valid, input class_in, output ready);
endinterface

/* hdl/swmv_rsp_if.sv */
// Result channel of the majority vote block: valid/ready plus the vote result.
// Depends on swmv_pkg.
interface swmv_rsp_if;
   import swmv_pkg::*;

   logic      valid;
   logic      ready;
   logic      result_valid;
   class_type majority_class;

   modport source (output valid, output result_valid, output majority_class, input ready);
   modport sink   (input valid, input result_valid, input majority_class, output ready);
endinterface

/* hdl/sliding_window_majority_vote.sv */
// Sliding-window majority vote: top level. Depends on swmv_pkg, swmv_req_if,
// swmv_rsp_if, swmv_hist_cell and swmv_tally_cell.
//
// Use: send one class index per transaction on req (valid/ready); each one
// gives exactly one transaction on rsp. The first WINDOW transactions only
// fill the window and return result_valid 0, majority_class 0. After that
// each transaction drops the oldest entry, appends the new one and returns
// the most frequent class below num_classes, lowest index on ties.
// csr_wr_en/csr_wr_data write num_classes (values above MAX_CLASSES count
// as MAX_CLASSES); write it only while the block is idle.
// Sequence: a filling transaction is accepted and then loads its result. A
// voting transaction is accepted, rotates the history chain past the counter
// cells, shifts the counter chain past the max search, then loads the result.
// req is ready whenever the block is idle, even while a result still waits
// on rsp; a finished result then holds until the rsp slot is free.
// Reset: synchronous, active high; clears fill level, control and rsp.valid,
// and sets num_classes to 2. History content needs no reset.
module sliding_window_majority_vote (
   input  logic                       clock,
   input  logic                       reset,
   swmv_req_if.sink                   req,
   swmv_rsp_if.source                 rsp,
   input  logic                       csr_wr_en,
   input  logic [swmv_pkg::NCLS_W-1:0] csr_wr_data
);
   import swmv_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ROT  = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   // control state
   logic [1:0]        state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [ROT_W-1:0]  rot_cnt_ff, rot_cnt_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [NCLS_W-1:0] num_classes_ff, num_classes_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   logic              res_full_ff, res_full_in;
   class_type         best_ff, best_in;
   count_type         best_cnt_ff, best_cnt_in;
   logic              rsp_result_ff, rsp_result_in;
   class_type         rsp_class_ff, rsp_class_in;

   logic              accept;
   logic              window_full;
   logic              rsp_load;
   logic [NCLS_W-1:0] n_eff;

   class_type         hist_q [WINDOW];
   class_type         tail_in;
   logic              hist_shift;

   count_type         tally_q [TALLY_N];
   logic              in_rot;
   logic              in_scan;

   assign req.ready   = (state_ff == S_IDLE);
   assign accept      = req.valid && req.ready;
   assign window_full = (fill_ff == FILL_W'(WINDOW));
   assign n_eff       = (num_classes_ff > NCLS_W'(MAX_CLASSES)) ?
                        NCLS_W'(MAX_CLASSES) : num_classes_ff;
   assign in_rot      = (state_ff == S_ROT);
   assign in_scan     = (state_ff == S_SCAN);
   assign rsp_load    = (state_ff == S_DONE) && (!rsp_valid_ff || rsp.ready);

   // History chain: shift the new entry in at the tail on a transaction, then
   // close the chain into a ring while counting so the head visits every entry
   // once and the window returns to its original order.
   assign hist_shift = accept || in_rot;
   assign tail_in    = in_rot ? hist_q[0] : req.class_in;

   for (genvar i = 0; i < WINDOW; i++) begin : g_hist
      class_type d;
      if (i == WINDOW - 1) begin : g_tail
         assign d = tail_in;
      end else begin : g_mid
         assign d = hist_q[i+1];
      end
      swmv_hist_cell u_cell (
         .clock    (clock),
         .shift_en (hist_shift),
         .d_in     (d),
         .q        (hist_q[i])
      );
   end

   // Counter chain: cell i counts head entries equal to i (if i takes part in
   // the vote), then the chain shifts toward cell 0 for the max search.
   for (genvar i = 0; i < TALLY_N; i++) begin : g_tally
      tally_ctl_type ctl;
      count_type     d;
      assign ctl.clear = accept;
      assign ctl.shift = in_scan;
      assign ctl.inc   = in_rot && (hist_q[0] == CLASS_W'(i)) && (NCLS_W'(i) < n_eff);
      if (i == TALLY_N - 1) begin : g_last
         assign d = '0;
      end else begin : g_mid
         assign d = tally_q[i+1];
      end
      swmv_tally_cell u_cell (
         .clock (clock),
         .ctl   (ctl),
         .d_in  (d),
         .q     (tally_q[i])
      );
   end

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      rot_cnt_in     = rot_cnt_ff;
      scan_idx_in    = scan_idx_ff;
      num_classes_in = csr_wr_en ? csr_wr_data : num_classes_ff;
      rsp_valid_in   = rsp_valid_ff;
      res_full_in    = res_full_ff;
      best_in        = best_ff;
      best_cnt_in    = best_cnt_ff;
      rsp_result_in  = rsp_result_ff;
      rsp_class_in   = rsp_class_ff;

      // drop the shown result once the sink takes it
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               best_in     = '0;
               best_cnt_in = '0;
               rot_cnt_in  = '0;
               if (window_full) begin
                  res_full_in = 1'b1;
                  state_in    = S_ROT;
               end else begin
                  res_full_in = 1'b0;
                  fill_in     = fill_ff + FILL_W'(1);
                  state_in    = S_DONE;
               end
            end
         end
         S_ROT: begin
            rot_cnt_in = rot_cnt_ff + ROT_W'(1);
            if (rot_cnt_ff == ROT_W'(WINDOW - 1)) begin
               scan_idx_in = '0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            // strict compare keeps the lowest index on ties
            if ((NCLS_W'(scan_idx_ff) < n_eff) && (tally_q[0] > best_cnt_ff)) begin
               best_in     = CLASS_W'(scan_idx_ff);
               best_cnt_in = tally_q[0];
            end
            scan_idx_in = scan_idx_ff + IDX_W'(1);
            if (scan_idx_ff == IDX_W'(TALLY_N - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the result register is free
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = res_full_ff;
               rsp_class_in  = res_full_ff ? best_ff : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         fill_ff        <= '0;
         rot_cnt_ff     <= '0;
         scan_idx_ff    <= '0;
         num_classes_ff <= NCLS_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fill_ff        <= fill_in;
         rot_cnt_ff     <= rot_cnt_in;
         scan_idx_ff    <= scan_idx_in;
         num_classes_ff <= num_classes_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_full_ff   <= res_full_in;
      best_ff       <= best_in;
      best_cnt_ff   <= best_cnt_in;
      rsp_result_ff <= rsp_result_in;
      rsp_class_ff  <= rsp_class_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.result_valid   = rsp_result_ff;
   assign rsp.majority_class = rsp_class_ff;

`ifndef SYNTHESIS
   // a valid vote is only ever reported once the window has filled
   a_valid_needs_full: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.result_valid) |-> window_full)
      else $error("vote result reported before the window filled");

   // a nonzero winner must be a class that takes part in the vote
   a_winner_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.result_valid && (rsp.majority_class != '0)) |->
      (NCLS_W'(rsp.majority_class) < n_eff))
      else $error("winning class outside the counted classes");

   // no class can collect more votes than the window holds
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      in_scan |-> (best_cnt_ff <= count_type'(WINDOW)))
      else $error("vote count exceeds window size");

   // the counting pass always starts from a full window
   a_rot_full: assert property (@(posedge clock) disable iff (reset)
      (accept && window_full) |=> (in_rot && res_full_ff))
      else $error("counting pass started without a full window");
`endif
endmodule

/* hdl/swmv_hist_cell.sv */
// One window entry of the history shift chain; takes the entry on d_in on shift.
// Depends on swmv_pkg.
module swmv_hist_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  swmv_pkg::class_type d_in,
   output swmv_pkg::class_type q
);
   import swmv_pkg::*;

   class_type entry_ff;
   class_type entry_in;

   always_comb begin
      entry_in = shift_en ? d_in : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;
endmodule

/* hdl/swmv_tally_cell.sv */
// One vote counter of the tally chain: clear, count a vote, or take the
// neighbor's count while the chain is scanned. Depends on swmv_pkg.
module swmv_tally_cell (
   input  logic                   clock,
   input  swmv_pkg::tally_ctl_type ctl,
   input  swmv_pkg::count_type     d_in,
   output swmv_pkg::count_type     q
);
   import swmv_pkg::*;

   count_type count_ff;
   count_type count_in;

   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.shift) begin
         count_in = d_in;
      end else if (ctl.inc) begin
         count_in = count_ff + count_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

   assign q = count_ff;
endmodule
